// ===== design/npcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npcm_pkg
// shared types and constants of the nearest palette color mapper
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int COLOR_W = 8;
  localparam int ENTRY_W = 3 * COLOR_W;
  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;
  localparam int DIST_W  = 18;
  localparam int SQ_W    = 2 * COLOR_W;

  // larger than any real distance, so entry 0 always wins the first compare
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256);
  localparam logic [DIST_W-1:0] DIST_MAX   = DIST_W'(3 * 255 * 255);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // control from the sequencer to the distance datapath
  typedef struct packed {
    logic clear;  // new pixel, restart the running minimum
    logic issue;  // palette read issued this cycle
    logic last;   // this read is the final entry of the search
  } search_ctl_t;

endpackage

// ===== design/nearest_palette_color_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_unit
// maps rgb pixels to the nearest entry of a loaded palette
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | mode, entry_index, red, green, blue,
//           |                     | last_pixel
//  output   | out_valid/out_stall | color_index, min_distance, frame_end
//  config   | cfg_write           | cfg_data (color_count)
//
// a palette write item gives no result
// a pixel item makes one palette read per cycle from the single read port,
// then drains through two datapath stages and waits in the handoff state
// reset clears the sequencer, the output valid and color_count (to 256);
// palette contents stay undefined until written
// a stalled output holds its item; the next pixel may search meanwhile and
// waits only at handoff
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_unit #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // config
  input  logic                            cfg_write,
  input  logic [npcm_pkg::COUNT_W-1:0]    cfg_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [npcm_pkg::INDEX_W-1:0]    entry_index,
  input  logic [npcm_pkg::COLOR_W-1:0]    red,
  input  logic [npcm_pkg::COLOR_W-1:0]    green,
  input  logic [npcm_pkg::COLOR_W-1:0]    blue,
  input  logic                            last_pixel,
  // output items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [npcm_pkg::INDEX_W-1:0]    color_index,
  output logic [npcm_pkg::DIST_W-1:0]     min_distance,
  output logic                            frame_end
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  // configuration register
  logic [npcm_pkg::COUNT_W-1:0] color_count;

  // pixel held for the duration of its search
  logic [npcm_pkg::COLOR_W-1:0] px_red, px_green, px_blue;
  logic                         px_last;

  npcm_pkg::search_ctl_t        ctl;
  logic                         wr_en;
  logic [AW-1:0]                rd_addr;
  logic [npcm_pkg::ENTRY_W-1:0] rd_data;
  logic [AW-1:0]                best_idx;
  logic [npcm_pkg::DIST_W-1:0]  best_dist;
  logic                         search_done;
  logic                         out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= npcm_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      color_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      px_red   <= red;
      px_green <= green;
      px_blue  <= blue;
      px_last  <= last_pixel;
    end
  end

  npcm_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .AW            (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .mode        (mode),
    .entry_index (entry_index),
    .color_count (color_count),
    .search_done (search_done),
    .out_stall   (out_stall),
    .in_stall    (in_stall),
    .wr_en       (wr_en),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .out_load    (out_load),
    .out_valid   (out_valid)
  );

  // palette: written straight from the input item, swept once per pixel
  npcm_ram #(
    .WIDTH (npcm_pkg::ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_index[AW-1:0]),
    .wr_data ({red, green, blue}),
    .rd_en   (ctl.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npcm_nearest #(
    .AW (AW)
  ) u_nearest (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .px_red    (px_red),
    .px_green  (px_green),
    .px_blue   (px_blue),
    .best_idx  (best_idx),
    .best_dist (best_dist),
    .done      (search_done)
  );

  // output register, loaded only when empty or being taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      color_index  <= npcm_pkg::INDEX_W'(best_idx);
      min_distance <= best_dist;
      frame_end    <= px_last;
    end
  end

  // no palette write while a search sweep is reading
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && ctl.issue))
    else $error("palette write during search sweep");

  // the search only completes while the block is busy
  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    search_done |-> in_stall)
    else $error("search completion while idle");

  // a finished search holds a real distance
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    search_done |=> (best_dist <= npcm_pkg::DIST_MAX))
    else $error("minimum distance out of range");

  // the output register never overwrites an item not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("output item overwritten");

endmodule

// ===== design/npcm_ram.sv =====
// ----------------------------------------------------------------------------
// npcm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/npcm_nearest.sv =====
// ----------------------------------------------------------------------------
// npcm_nearest
// distance datapath: squares stage, then sum and running minimum
// ----------------------------------------------------------------------------
module npcm_nearest #(
  parameter int AW = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  npcm_pkg::search_ctl_t             ctl,
  input  logic [AW-1:0]                     rd_addr,
  input  logic [npcm_pkg::ENTRY_W-1:0]      rd_data,
  input  logic [npcm_pkg::COLOR_W-1:0]      px_red,
  input  logic [npcm_pkg::COLOR_W-1:0]      px_green,
  input  logic [npcm_pkg::COLOR_W-1:0]      px_blue,
  output logic [AW-1:0]                     best_idx,
  output logic [npcm_pkg::DIST_W-1:0]       best_dist,
  output logic                              done
);

  localparam int CW = npcm_pkg::COLOR_W;
  localparam int SW = npcm_pkg::SQ_W;
  localparam int DW = npcm_pkg::DIST_W;

  // stage 1: aligned with ram read data
  logic          v1, l1;
  logic [AW-1:0] a1;
  // stage 2: registered squares
  logic          v2, l2;
  logic [AW-1:0] a2;
  logic [SW-1:0] sq_r, sq_g, sq_b;

  logic signed [CW:0]     dr, dg, db;
  logic signed [2*CW+1:0] pr, pg, pb;
  logic [DW-1:0]          sum_sq;
  logic                   better;

  always_comb begin
    dr = $signed({1'b0, rd_data[3*CW-1:2*CW]}) - $signed({1'b0, px_red});
    dg = $signed({1'b0, rd_data[2*CW-1:CW]})   - $signed({1'b0, px_green});
    db = $signed({1'b0, rd_data[CW-1:0]})      - $signed({1'b0, px_blue});
    pr = dr * dr;
    pg = dg * dg;
    pb = db * db;
  end

  assign sum_sq = DW'(sq_r) + DW'(sq_g) + DW'(sq_b);
  assign better = v2 && (sum_sq < best_dist);
  assign done   = v2 && l2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    l1   <= ctl.last;
    a1   <= rd_addr;
    l2   <= l1;
    a2   <= a1;
    sq_r <= pr[SW-1:0];
    sq_g <= pg[SW-1:0];
    sq_b <= pb[SW-1:0];
    if (ctl.clear) begin
      best_dist <= npcm_pkg::DIST_START;
      best_idx  <= '0;
    end else if (better) begin
      // strict compare keeps the lowest index on ties
      best_dist <= sum_sq;
      best_idx  <= a2;
    end
  end

endmodule

// ===== design/npcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// npcm_ctrl
// sequencer: input handshake, palette writes, read sweep, output handoff
// ----------------------------------------------------------------------------
module npcm_ctrl #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF,
  parameter int AW            = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           mode,
  input  logic [npcm_pkg::INDEX_W-1:0]   entry_index,
  input  logic [npcm_pkg::COUNT_W-1:0]   color_count,
  input  logic                           search_done,
  input  logic                           out_stall,
  output logic                           in_stall,
  output logic                           wr_en,
  output npcm_pkg::search_ctl_t          ctl,
  output logic [AW-1:0]                  rd_addr,
  output logic                           out_load,
  output logic                           out_valid
);

  localparam int CNW = npcm_pkg::COUNT_W;
  localparam logic [CNW-1:0] DEPTH_C = CNW'(PALETTE_DEPTH);

  npcm_pkg::state_t state, state_next;
  logic [AW-1:0]    k, k_next;
  logic [AW-1:0]    last_k, last_k_next;
  logic [CNW-1:0]   count_eff;
  logic             out_valid_next;
  logic             take;

  always_comb begin
    count_eff = color_count;
    if (count_eff == '0) begin
      count_eff = CNW'(1);
    end
    if (count_eff > DEPTH_C) begin
      count_eff = DEPTH_C;
    end
  end

  assign take = in_valid && (state == npcm_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next  = state;
    k_next      = k;
    last_k_next = last_k;
    case (state)
      npcm_pkg::ST_IDLE: begin
        if (take && mode == npcm_pkg::MODE_PIXEL) begin
          state_next  = npcm_pkg::ST_SEARCH;
          k_next      = '0;
          last_k_next = AW'(count_eff - CNW'(1));
        end
      end
      npcm_pkg::ST_SEARCH: begin
        k_next = k + AW'(1);
        if (k == last_k) begin
          state_next = npcm_pkg::ST_DRAIN;
        end
      end
      npcm_pkg::ST_DRAIN: begin
        if (search_done) begin
          state_next = npcm_pkg::ST_FINISH;
        end
      end
      npcm_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = npcm_pkg::ST_IDLE;
        end
      end
      default: state_next = npcm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != npcm_pkg::ST_IDLE);
    wr_en     = take && (mode == npcm_pkg::MODE_WRITE)
                && ({1'b0, entry_index} < DEPTH_C);
    ctl.clear = take && (mode == npcm_pkg::MODE_PIXEL);
    ctl.issue = (state == npcm_pkg::ST_SEARCH);
    ctl.last  = (state == npcm_pkg::ST_SEARCH) && (k == last_k);
    rd_addr   = k;
    out_load  = (state == npcm_pkg::ST_FINISH) && (!out_valid || !out_stall);
    out_valid_next = out_load || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npcm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    last_k <= last_k_next;
  end

endmodule
